// ----- rtl/core/rsas_pkg.sv -----
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared types and constants for the radix sign-magnitude add/sub block.
// ----------------------------------------------------------------------------
package rsas_pkg;

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    // radix limits and reset value
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;

    // ascii mapping: '0' base for 0..9, 'A' - 10 for 10..35
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = 7'd55;
    localparam logic [CHAR_W-1:0]  CHAR_LAST   = 7'd90;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 6'd10;

    // one input beat
    typedef struct packed {
        logic [DIGIT_W-1:0] digit_a;
        logic [DIGIT_W-1:0] digit_b;
        logic               sign_a;
        logic               sign_b;
        logic               a_larger;
        logic               last;
    } item_t;

    // one result beat
    typedef struct packed {
        logic [CHAR_W-1:0] result_char;
        logic              result_negative;
        logic              overflow;
        logic              done_res;
    } result_t;

endpackage

// ----- rtl/core/radix_sign_magnitude_add_sub.sv -----
// ----------------------------------------------------------------------------
// radix_sign_magnitude_add_sub
// Adds or subtracts two sign-magnitude numbers given as radix-B digit
// strings, least significant digit first, one digit pair per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one digit pair and yields one result beat with the
// digit as an ASCII character ('0'-'9', 'A'-'Z'). Signs and a_larger are read
// on the first beat of a number; last marks its most significant pair. The
// block takes one beat per clock unless m_ready holds off the result side: a
// beat is registered in the input register, the digit core computes it in a
// single pass and it lands in the result register, the only loop being the
// one-bit carry/borrow between digits. The radix register (reset 10, clamped
// to 2..36 in the core) is written through cfg_wr_en/cfg_wr_data, by the user
// only while no number is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module radix_sign_magnitude_add_sub
    import rsas_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [DIGIT_W-1:0] cfg_wr_data,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DIGIT_W-1:0] s_digit_a,
    input  logic [DIGIT_W-1:0] s_digit_b,
    input  logic               s_sign_a,
    input  logic               s_sign_b,
    input  logic               s_a_larger,
    input  logic               s_last,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAR_W-1:0]  m_result_char,
    output logic               m_result_negative,
    output logic               m_overflow,
    output logic               m_done_res
);

    logic [DIGIT_W-1:0] radix_reg;
    item_t              s_item;
    item_t              item;
    logic               item_valid;
    logic               advance;
    result_t            result;
    result_t            out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    // radix register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= cfg_wr_data;
        end
    end

    assign s_item.digit_a  = s_digit_a;
    assign s_item.digit_b  = s_digit_b;
    assign s_item.sign_a   = s_sign_a;
    assign s_item.sign_b   = s_sign_b;
    assign s_item.a_larger = s_a_larger;
    assign s_item.last     = s_last;

    // beat moves into the result register when that one is free or drains
    assign advance = item_valid && (!out_valid_reg || m_ready);

    rsas_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rsas_digit_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .radix   (radix_reg),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    // result register
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_result_char     = out_reg.result_char;
    assign m_result_negative = out_reg.result_negative;
    assign m_overflow        = out_reg.overflow;
    assign m_done_res        = out_reg.done_res;

endmodule

// ----- rtl/core/rsas_in_reg.sv -----
// ----------------------------------------------------------------------------
// rsas_in_reg
// Input register: captures one beat and holds it until the digit core
// advances it into the result register.
// ----------------------------------------------------------------------------
module rsas_in_reg
    import rsas_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // stage may refill when empty or when its beat moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid || (valid_reg && !advance);

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/core/rsas_digit_core.sv -----
// ----------------------------------------------------------------------------
// rsas_digit_core
// Per-digit add or subtract with the carry/borrow and per-number mode state.
// State moves forward on each advanced beat.
// ----------------------------------------------------------------------------
module rsas_digit_core
    import rsas_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [DIGIT_W-1:0] radix,
    input  logic               advance,
    input  item_t              item,
    output result_t            result
);

    logic carry_reg,    carry_next;
    logic first_reg,    first_next;
    logic sub_reg,      sub_next;
    logic swap_reg,     swap_next;
    logic neg_reg,      neg_next;
    logic nonzero_reg,  nonzero_next;

    logic [DIGIT_W-1:0] r_eff;
    logic [DIGIT_W-1:0] a_eff;
    logic [DIGIT_W-1:0] b_eff;
    logic               sub_eff;
    logic               swap_eff;
    logic               neg_eff;
    logic               carry_eff;
    logic               nonzero_eff;
    logic [DIGIT_W-1:0] x_op;
    logic [DIGIT_W-1:0] y_op;
    logic [DIGIT_W:0]   take;
    logic [DIGIT_W:0]   sum;
    logic [DIGIT_W:0]   diff;
    logic [DIGIT_W-1:0] digit;
    logic               carry_out;

    // clamp radix and digits into range
    always_comb begin
        if (radix < RADIX_MIN) begin
            r_eff = RADIX_MIN;
        end else if (radix > RADIX_MAX) begin
            r_eff = RADIX_MAX;
        end else begin
            r_eff = radix;
        end
        a_eff = (item.digit_a >= r_eff) ? r_eff - 6'd1 : item.digit_a;
        b_eff = (item.digit_b >= r_eff) ? r_eff - 6'd1 : item.digit_b;
    end

    // mode for this beat: latched on the first digit of a number
    always_comb begin
        if (first_reg) begin
            sub_eff     = item.sign_a != item.sign_b;
            swap_eff    = sub_eff && !item.a_larger;
            neg_eff     = sub_eff ? (item.a_larger ? item.sign_a : item.sign_b)
                                  : item.sign_a;
            carry_eff   = 1'b0;
            nonzero_eff = 1'b0;
        end else begin
            sub_eff     = sub_reg;
            swap_eff    = swap_reg;
            neg_eff     = neg_reg;
            carry_eff   = carry_reg;
            nonzero_eff = nonzero_reg;
        end
    end

    // digit arithmetic
    always_comb begin
        x_op = swap_eff ? b_eff : a_eff;
        y_op = swap_eff ? a_eff : b_eff;
        take = {1'b0, y_op} + {{DIGIT_W{1'b0}}, carry_eff};
        sum  = {1'b0, a_eff} + {1'b0, b_eff} + {{DIGIT_W{1'b0}}, carry_eff};
        if (sub_eff) begin
            if ({1'b0, x_op} >= take) begin
                diff      = {1'b0, x_op} - take;
                carry_out = 1'b0;
            end else begin
                diff      = {1'b0, x_op} + {1'b0, r_eff} - take;
                carry_out = 1'b1;
            end
        end else begin
            if (sum >= {1'b0, r_eff}) begin
                diff      = sum - {1'b0, r_eff};
                carry_out = 1'b1;
            end else begin
                diff      = sum;
                carry_out = 1'b0;
            end
        end
        digit = diff[DIGIT_W-1:0];
    end

    // next state
    always_comb begin
        nonzero_next = nonzero_eff || (sub_eff && (digit != '0));
        sub_next     = sub_eff;
        swap_next    = swap_eff;
        neg_next     = neg_eff;
        first_next   = item.last;
        carry_next   = item.last ? 1'b0 : carry_out;
    end

    // result beat
    always_comb begin
        result.result_char     = (digit < DEC_LIMIT)
                                 ? {1'b0, digit} + CHAR_ZERO
                                 : {1'b0, digit} + CHAR_ALPHA;
        result.result_negative = sub_eff ? (neg_eff && nonzero_next) : neg_eff;
        result.overflow        = !sub_eff && item.last && carry_out;
        result.done_res        = item.last;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg   <= 1'b0;
            first_reg   <= 1'b1;
            sub_reg     <= 1'b0;
            swap_reg    <= 1'b0;
            neg_reg     <= 1'b0;
            nonzero_reg <= 1'b0;
        end else if (advance) begin
            carry_reg   <= carry_next;
            first_reg   <= first_next;
            sub_reg     <= sub_next;
            swap_reg    <= swap_next;
            neg_reg     <= neg_next;
            nonzero_reg <= nonzero_next;
        end
    end

    // a last digit always leaves the core ready for a fresh number
    a_last_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.last |=> first_reg && !carry_reg)
        else $error("state not cleared after last digit");

    // operands are only swapped in subtract mode
    a_swap_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        swap_reg |-> sub_reg)
        else $error("swap without subtract mode");

    // output character stays in the digit alphabet
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> result.result_char >= CHAR_ZERO && result.result_char <= CHAR_LAST)
        else $error("result character out of range");

    // overflow only on the last digit of an addition
    a_ovf_add: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.overflow |-> item.last && !sub_eff)
        else $error("overflow outside last addition digit");

endmodule

// ----- verif/rsas_digit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsas_digit_checker
// Watches both channels of the radix add/sub block, predicts every result
// digit from the accepted input beats and compares it field by field.
// ----------------------------------------------------------------------------
module rsas_digit_checker
    import rsas_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [DIGIT_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [DIGIT_W-1:0] s_digit_a,
    input  logic [DIGIT_W-1:0] s_digit_b,
    input  logic               s_sign_a,
    input  logic               s_sign_b,
    input  logic               s_a_larger,
    input  logic               s_last,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [CHAR_W-1:0]  m_result_char,
    input  logic               m_result_negative,
    input  logic               m_overflow,
    input  logic               m_done_res,
    output int                 fail_count,
    output int                 pending
);

    localparam int MAX_REPORTS = 10;

    // predictor copy of the register and the per-number state
    logic [DIGIT_W-1:0] radix_q;
    logic               carry_q;
    logic               first_q;
    logic               sub_q;
    logic               swap_q;
    logic               neg_q;
    logic               nonzero_q;

    result_t expected_digits[$];
    item_t   beat_in;
    result_t beat_out;

    assign beat_in  = {s_digit_a, s_digit_b, s_sign_a, s_sign_b, s_a_larger, s_last};
    assign beat_out = {m_result_char, m_result_negative, m_overflow, m_done_res};

    // one digit of the sign-magnitude sum, advancing the carry/borrow chain
    function automatic result_t add_sub_digit(item_t it);
        int      r;
        int      a;
        int      b;
        int      x;
        int      y;
        int      take;
        int      d;
        result_t res;
        r = radix_q;
        if (r < RADIX_MIN) r = RADIX_MIN;
        if (r > RADIX_MAX) r = RADIX_MAX;
        a = it.digit_a;
        b = it.digit_b;
        if (a >= r) a = r - 1;
        if (b >= r) b = r - 1;

        // first pair of a number latches the mode
        if (first_q) begin
            sub_q     = (it.sign_a != it.sign_b);
            swap_q    = sub_q && !it.a_larger;
            neg_q     = sub_q ? (it.a_larger ? it.sign_a : it.sign_b) : it.sign_a;
            carry_q   = 1'b0;
            nonzero_q = 1'b0;
            first_q   = 1'b0;
        end

        res = '0;
        if (sub_q) begin
            x    = swap_q ? b : a;
            y    = swap_q ? a : b;
            take = y + carry_q;
            if (x >= take) begin
                d       = x - take;
                carry_q = 1'b0;
            end else begin
                d       = x + r - take;
                carry_q = 1'b1;
            end
            if (d != 0) nonzero_q = 1'b1;
            // a zero difference stays positive
            res.result_negative = neg_q && nonzero_q;
        end else begin
            d = a + b + carry_q;
            if (d >= r) begin
                d       = d - r;
                carry_q = 1'b1;
            end else begin
                carry_q = 1'b0;
            end
            res.result_negative = neg_q;
            res.overflow        = it.last && carry_q;
        end

        res.result_char = (d < DEC_LIMIT) ? CHAR_W'(d) + CHAR_ZERO : CHAR_W'(d) + CHAR_ALPHA;
        res.done_res    = it.last;

        if (it.last) begin
            first_q = 1'b1;
            carry_q = 1'b0;
        end
        return res;
    endfunction

    // track register writes, queue predictions, compare result beats
    always @(posedge aclk) begin : track
        result_t want;
        if (!aresetn) begin
            radix_q    = RADIX_RESET;
            carry_q    = 1'b0;
            first_q    = 1'b1;
            sub_q      = 1'b0;
            swap_q     = 1'b0;
            neg_q      = 1'b0;
            nonzero_q  = 1'b0;
            fail_count = 0;
            expected_digits.delete();
        end else begin
            if (cfg_wr_en) radix_q = cfg_wr_data;
            if (s_valid && s_ready)
                expected_digits = {expected_digits, add_sub_digit(beat_in)};
            if (m_valid && m_ready) begin
                if (expected_digits.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected result beat: char %0d neg %0b ovf %0b done %0b",
                                 m_result_char, m_result_negative, m_overflow, m_done_res);
                    fail_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (want.result_char !== beat_out.result_char ||
                        want.result_negative !== beat_out.result_negative ||
                        want.overflow !== beat_out.overflow ||
                        want.done_res !== beat_out.done_res) begin
                        if (fail_count < MAX_REPORTS)
                            $display("digit mismatch: exp %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                                     want.result_char, want.result_negative, want.overflow,
                                     want.done_res, m_result_char, m_result_negative,
                                     m_overflow, m_done_res);
                        fail_count++;
                    end
                end
            end
        end
        pending <= expected_digits.size();
    end

endmodule

// ----- verif/tb_radix_sign_magnitude_add_sub.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_sign_magnitude_add_sub
// Drives digit strings through the radix add/sub block over several radix
// settings, with random idle on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_radix_sign_magnitude_add_sub;
    import rsas_pkg::*;

    localparam int PHASE_BEATS  = 58;
    localparam int NUM_PHASES   = 9;
    localparam int MAX_IDLE     = 13;
    localparam int MAX_DIGITS   = 6;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [DIGIT_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [DIGIT_W-1:0] s_digit_a;
    logic [DIGIT_W-1:0] s_digit_b;
    logic               s_sign_a;
    logic               s_sign_b;
    logic               s_a_larger;
    logic               s_last;
    logic               m_valid;
    logic               m_ready;
    logic [CHAR_W-1:0]  m_result_char;
    logic               m_result_negative;
    logic               m_overflow;
    logic               m_done_res;

    int fail_count;
    int pending;
    int stall_cycles;
    int beats_sent;
    bit tx_burst;
    bit rx_burst;
    bit hold_req;

    radix_sign_magnitude_add_sub dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_digit_a         (s_digit_a),
        .s_digit_b         (s_digit_b),
        .s_sign_a          (s_sign_a),
        .s_sign_b          (s_sign_b),
        .s_a_larger        (s_a_larger),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_char     (m_result_char),
        .m_result_negative (m_result_negative),
        .m_overflow        (m_overflow),
        .m_done_res        (m_done_res)
    );

    rsas_digit_checker u_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_digit_a         (s_digit_a),
        .s_digit_b         (s_digit_b),
        .s_sign_a          (s_sign_a),
        .s_sign_b          (s_sign_b),
        .s_a_larger        (s_a_larger),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_char     (m_result_char),
        .m_result_negative (m_result_negative),
        .m_overflow        (m_overflow),
        .m_done_res        (m_done_res),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic item_t make_beat(int a, int b, bit sa, bit sb, bit big, bit last);
        item_t it;
        it.digit_a  = DIGIT_W'(a);
        it.digit_b  = DIGIT_W'(b);
        it.sign_a   = sa;
        it.sign_b   = sb;
        it.a_larger = big;
        it.last     = last;
        return it;
    endfunction

    // offer one beat after a random gap and hold it until taken
    task automatic send_beat(input item_t it);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_digit_a  <= it.digit_a;
        s_digit_b  <= it.digit_b;
        s_sign_a   <= it.sign_a;
        s_sign_b   <= it.sign_b;
        s_a_larger <= it.a_larger;
        s_last     <= it.last;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    // one number as a digit string, mostly well formed, sometimes noise
    task automatic send_number(input int eff_radix, input bit noisy);
        int                 len;
        int                 i;
        bit                 sa;
        bit                 sb;
        bit                 big;
        bit                 decided;
        logic [DIGIT_W-1:0] da[MAX_DIGITS];
        logic [DIGIT_W-1:0] db[MAX_DIGITS];
        len = $urandom_range(1, MAX_DIGITS);
        sa  = 1'($urandom_range(0, 1));
        sb  = 1'($urandom_range(0, 1));
        for (i = 0; i < len; i++) begin
            da[i] = noisy ? DIGIT_W'($urandom) : DIGIT_W'($urandom_range(0, eff_radix - 1));
            db[i] = noisy ? DIGIT_W'($urandom) : DIGIT_W'($urandom_range(0, eff_radix - 1));
        end
        // equal magnitudes now and then
        if (!noisy && $urandom_range(0, 7) == 0)
            for (i = 0; i < len; i++) db[i] = da[i];
        // magnitude compare from the top digit down
        big     = 1'b0;
        decided = 1'b0;
        for (i = len - 1; i >= 0; i--) begin
            if (!decided && da[i] != db[i]) begin
                big     = da[i] > db[i];
                decided = 1'b1;
            end
        end
        if (noisy) big = 1'($urandom_range(0, 1));
        for (i = 0; i < len; i++) begin
            if (i == 0 || !noisy)
                send_beat(make_beat(da[i], db[i], sa, sb, big, i == len - 1));
            else
                send_beat(make_beat(da[i], db[i], 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    i == len - 1));
        end
    endtask

    // radix write once the block has drained
    task automatic set_radix(input logic [DIGIT_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // result side: random ready, one long hold-off on request
    initial begin : receiver
        int gap;
        bit held;
        m_ready  = 1'b0;
        rx_burst = 1'b0;
        held     = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            gap = draw_gap(rx_burst);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [DIGIT_W-1:0] radix_plan[NUM_PHASES];
        logic [DIGIT_W-1:0] value;
        int                 eff;
        int                 p;
        int                 start;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_digit_a    = '0;
        s_digit_b    = '0;
        s_sign_a     = 1'b0;
        s_sign_b     = 1'b0;
        s_a_larger   = 1'b0;
        s_last       = 1'b0;
        beats_sent   = 0;
        tx_burst     = 1'b0;
        hold_req     = 1'b0;
        radix_plan   = '{6'd2, 6'd36, 6'd0, 6'd16, 6'd63, 6'd10, 6'd1, 6'd37, 6'd10};
        radix_plan[NUM_PHASES - 1] = DIGIT_W'($urandom_range(2, 36));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed numbers at the reset radix of ten
        send_beat(make_beat(5, 3, 0, 0, 1, 1));
        // like signs, carry dropped on the last digit
        send_beat(make_beat(9, 9, 1, 1, 0, 1));
        send_beat(make_beat(9, 1, 0, 0, 1, 0));
        send_beat(make_beat(9, 0, 0, 0, 1, 1));
        // negative zero sum keeps the common sign
        send_beat(make_beat(0, 0, 1, 1, 0, 1));
        // equal magnitudes with unlike signs give positive zero
        send_beat(make_beat(7, 7, 0, 1, 0, 0));
        send_beat(make_beat(3, 3, 0, 1, 0, 1));
        // unlike signs, larger operand negative
        send_beat(make_beat(2, 7, 1, 0, 1, 0));
        send_beat(make_beat(5, 1, 1, 0, 1, 1));
        send_beat(make_beat(3, 8, 0, 1, 0, 1));
        // wrong magnitude flag wraps around
        send_beat(make_beat(2, 8, 1, 0, 1, 1));
        // digits at or above the radix
        send_beat(make_beat(63, 40, 0, 0, 1, 1));
        send_beat(make_beat(0, 63, 1, 0, 0, 1));
        // borrow chain with leading zeros, signs ignored after the first pair
        send_beat(make_beat(0, 9, 1, 0, 1, 0));
        send_beat(make_beat(0, 9, 0, 1, 0, 0));
        send_beat(make_beat(1, 0, 1, 1, 0, 1));

        // random phases over a spread of radix settings
        for (p = 0; p < NUM_PHASES; p++) begin
            value = radix_plan[p];
            set_radix(value);
            eff = (value < RADIX_MIN) ? RADIX_MIN : (value > RADIX_MAX) ? RADIX_MAX : value;
            tx_burst = (p % 2 == 1);
            if (p == 1) hold_req = 1'b1;
            start = beats_sent;
            while (beats_sent - start < PHASE_BEATS)
                send_number(eff, $urandom_range(0, 6) == 0);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rsas_pkg.sv
rtl/core/rsas_in_reg.sv
rtl/core/rsas_digit_core.sv
rtl/core/radix_sign_magnitude_add_sub.sv
verif/rsas_digit_checker.sv
verif/tb_radix_sign_magnitude_add_sub.sv
